// File: rtl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared constants for the 2D convolution unit: widths, store depths,
// command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package c2d_pkg;

    // Element and accumulator widths
    localparam int DATA_W = 16;
    localparam int ACC_W  = 48;

    // Store geometry
    localparam int FEAT_AW = 13;
    localparam int WGT_AW  = 11;
    localparam int BIAS_AW = 3;

    // Output size arithmetic: spans stay below 2**SIZE_W
    localparam int SIZE_W   = 7;
    localparam int STRIDE_W = 4;

    // Commands carried in tuser
    localparam logic [1:0] CMD_FEATURE = 2'd0;
    localparam logic [1:0] CMD_WEIGHT  = 2'd1;
    localparam logic [1:0] CMD_BIAS    = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_IN_CH    = 3'd0;
    localparam logic [2:0] REG_IN_H     = 3'd1;
    localparam logic [2:0] REG_IN_W     = 3'd2;
    localparam logic [2:0] REG_OUT_CH   = 3'd3;
    localparam logic [2:0] REG_KER_W    = 3'd4;
    localparam logic [2:0] REG_KER_H    = 3'd5;
    localparam logic [2:0] REG_STRIDES  = 3'd6;
    localparam logic [2:0] REG_OPTIONS  = 3'd7;

endpackage

// File: rtl/c2d_divider.sv
// ----------------------------------------------------------------------------
// c2d_divider
// Restoring divider, one quotient bit per cycle. Used for the output map
// height and width.
// ----------------------------------------------------------------------------
module c2d_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [c2d_pkg::SIZE_W-1:0]         i_dividend,
    input  logic [c2d_pkg::STRIDE_W-1:0]       i_divisor,
    output logic                               o_done,
    output logic [c2d_pkg::SIZE_W-1:0]         o_quotient
);

    logic                              r_busy, n_busy;
    logic [2:0]                        r_cnt, n_cnt;
    logic [c2d_pkg::STRIDE_W:0]        r_rem, n_rem;
    logic [c2d_pkg::SIZE_W-1:0]        r_quo, n_quo;
    logic [c2d_pkg::STRIDE_W-1:0]      r_div;
    logic [c2d_pkg::STRIDE_W+1:0]      rem_sh;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh = {r_rem, r_quo[c2d_pkg::SIZE_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'(c2d_pkg::SIZE_W);
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (r_cnt == 3'd0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 3'd1;
                if (rem_sh >= {2'b00, r_div}) begin
                    n_rem = (c2d_pkg::STRIDE_W+1)'(rem_sh - {2'b00, r_div});
                    n_quo = {r_quo[c2d_pkg::SIZE_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[c2d_pkg::STRIDE_W:0];
                    n_quo = {r_quo[c2d_pkg::SIZE_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done     = r_busy && (r_cnt == 3'd0);
    assign o_quotient = r_quo;

endmodule

// File: rtl/conv2d_stride_pad_relu_unit.sv
// ----------------------------------------------------------------------------
// conv2d_stride_pad_relu_unit
// Direct 2D convolution over stored feature map, weights and biases, with
// stride, VALID/SAME padding and optional ReLU, one output per compute command.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser selects feature, weight or bias load, or a
//   compute of one output position. A load writes its store in the transfer
//   cycle and is ready again the next cycle; it gives no result.
//   A compute gives one result on m_axis: value, flat index, map size and a
//   status bit set when the position lies outside the output map.
//   The result is valid after two divisions for the output size, the setup
//   states CHECK, SETUP1 and SETUP2, then one multiply-accumulate per tap and
//   channel through the single shared multiplier fed by the feature and weight
//   memories, the drain and the final state; a position outside the output map
//   goes from CHECK straight to the final state. The input is not ready during
//   that time and takes the next command once the unit is idle again.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user
//   must write it only while idle, the block does not enforce it. Reset loads
//   the default registers and empties the result register; store contents are
//   undefined until written. A stalled receiver holds the result in the output
//   register; loads are still taken meanwhile, a later compute waits in S_FINAL.
// ----------------------------------------------------------------------------
module conv2d_stride_pad_relu_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // load_address[12:0], load_value[28:13], out_row[33:29], out_col[38:34],
    // out_channel[41:39], zero fill [47:42]
    input  logic [47:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // conv_value[47:0], out_index[60:48], out_height[66:61], out_width[72:67],
    // zero fill [79:73]
    output logic [79:0] m_axis_tdata,
    // status[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int DW = c2d_pkg::DATA_W;
    localparam int AW = c2d_pkg::ACC_W;
    localparam int SW = c2d_pkg::SIZE_W;
    localparam int FW = 20;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HSTART = 4'd1;
    localparam logic [3:0] S_HWAIT  = 4'd2;
    localparam logic [3:0] S_WSTART = 4'd3;
    localparam logic [3:0] S_WWAIT  = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_SETUP1 = 4'd6;
    localparam logic [3:0] S_SETUP2 = 4'd7;
    localparam logic [3:0] S_MAC    = 4'd8;
    localparam logic [3:0] S_DRAIN  = 4'd9;
    localparam logic [3:0] S_FINAL  = 4'd10;

    // Configuration registers
    logic [3:0] r_in_ch, r_out_ch;
    logic [5:0] r_in_h, r_in_w;
    logic [2:0] r_ker_w, r_ker_h;
    logic [7:0] r_strides;
    logic [1:0] r_options;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch   <= 4'd1;
            r_in_h    <= 6'd1;
            r_in_w    <= 6'd1;
            r_out_ch  <= 4'd1;
            r_ker_w   <= 3'd1;
            r_ker_h   <= 3'd1;
            r_strides <= 8'd17;
            r_options <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                c2d_pkg::REG_IN_CH:   r_in_ch   <= i_cfg_data[3:0];
                c2d_pkg::REG_IN_H:    r_in_h    <= i_cfg_data[5:0];
                c2d_pkg::REG_IN_W:    r_in_w    <= i_cfg_data[5:0];
                c2d_pkg::REG_OUT_CH:  r_out_ch  <= i_cfg_data[3:0];
                c2d_pkg::REG_KER_W:   r_ker_w   <= i_cfg_data[2:0];
                c2d_pkg::REG_KER_H:   r_ker_h   <= i_cfg_data[2:0];
                c2d_pkg::REG_STRIDES: r_strides <= i_cfg_data;
                c2d_pkg::REG_OPTIONS: r_options <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective kernel, stride and padding
    logic [2:0] kx, ky, px, py;
    logic [3:0] sx, sy;
    logic signed [7:0] span_h, span_w;

    assign kx = (r_ker_w == 3'd0) ? 3'd1 : r_ker_w;
    assign ky = (r_ker_h == 3'd0) ? 3'd1 : r_ker_h;
    assign sx = (r_strides[3:0] == 4'd0) ? 4'd1 : r_strides[3:0];
    assign sy = (r_strides[7:4] == 4'd0) ? 4'd1 : r_strides[7:4];
    assign px = r_options[0] ? ((kx - 3'd1) >> 1) : 3'd0;
    assign py = r_options[0] ? ((ky - 3'd1) >> 1) : 3'd0;
    assign span_h = $signed({2'b00, r_in_h}) + $signed({4'b0000, py, 1'b0})
                  - $signed({5'b00000, ky});
    assign span_w = $signed({2'b00, r_in_w}) + $signed({4'b0000, px, 1'b0})
                  - $signed({5'b00000, kx});

    // Input fields
    logic       acc_in;
    logic [1:0] in_cmd;
    logic [12:0] in_addr;
    logic [DW-1:0] in_val;

    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign in_cmd  = s_axis_tuser;
    assign in_addr = s_axis_tdata[12:0];
    assign in_val  = s_axis_tdata[28:13];

    // Sequencer and compute registers
    logic [3:0]  r_state;
    logic [4:0]  r_row, r_col;
    logic [2:0]  r_och;
    logic [SW-1:0] r_hout, r_wout;
    logic        r_oor;
    logic signed [10:0] r_h0, r_w0, r_h, r_w;
    logic [12:0] r_tmp, r_idx;
    logic [9:0]  r_winc;
    logic signed [17:0] r_hw;
    logic signed [FW-1:0] r_fi, r_fi_row;
    logic [14:0] r_wi;
    logic [3:0]  r_c;
    logic [2:0]  r_jj, r_ii;

    // Shared divider
    logic          div_start, div_done;
    logic [SW-1:0] div_dividend, div_quo;
    logic [3:0]    div_divisor;

    assign div_start    = (r_state == S_HSTART) || (r_state == S_WSTART);
    assign div_dividend = (r_state == S_HSTART)
                        ? (span_h[7] ? '0 : span_h[SW-1:0])
                        : (span_w[7] ? '0 : span_w[SW-1:0]);
    assign div_divisor  = (r_state == S_HSTART) ? sy : sx;

    c2d_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Setup arithmetic
    logic [8:0]  row_sy, col_sx;
    logic [12:0] tmp_full;
    logic [16:0] idx_full;
    logic [9:0]  winc_full;
    logic signed [17:0] hw_full;
    logic signed [23:0] fi_full;
    logic        oor;

    assign row_sy    = r_row * sy;
    assign col_sx    = r_col * sx;
    assign tmp_full  = r_row * r_wout + {8'd0, r_col};
    assign idx_full  = r_tmp * r_out_ch + {14'd0, r_och};
    assign winc_full = r_in_w * r_in_ch;
    assign hw_full   = r_h0 * $signed({1'b0, r_in_w});
    assign fi_full   = ($signed({r_hw[17], r_hw}) + $signed({{8{r_w0[10]}}, r_w0}))
                     * $signed({1'b0, r_in_ch});
    assign oor = ({2'b00, r_row} >= r_hout) || ({2'b00, r_col} >= r_wout)
              || ({1'b0, r_och} >= r_out_ch);

    // Tap address checks
    logic tap_ok, last_c, last_j, last_i;

    assign tap_ok = !r_h[10] && ($signed(r_h) < $signed({5'd0, r_in_h}))
                 && !r_w[10] && ($signed(r_w) < $signed({5'd0, r_in_w}))
                 && (r_fi[FW-1:c2d_pkg::FEAT_AW] == '0)
                 && (r_wi[14:c2d_pkg::WGT_AW] == '0);
    assign last_c = (r_c == r_in_ch - 4'd1);
    assign last_j = (r_jj == kx - 3'd1);
    assign last_i = (r_ii == ky - 3'd1);

    // Pipeline: memory read, multiply, accumulate
    logic r_p1, r_p2;
    logic signed [DW-1:0] r_frd, r_wrd, r_bias;
    logic signed [2*DW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    // Result assembly
    logic signed [AW-1:0] sum;
    logic                 relu_zero;
    logic                 out_free;

    assign sum       = r_acc + AW'(r_bias);
    assign relu_zero = r_options[1] && sum[AW-1];
    assign out_free  = !m_axis_tvalid || m_axis_tready;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in && (in_cmd == c2d_pkg::CMD_COMPUTE)) begin
                        r_state <= S_HSTART;
                    end
                end
                S_HSTART: r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (div_done) begin
                        r_state <= S_WSTART;
                    end
                end
                S_WSTART: r_state <= S_WWAIT;
                S_WWAIT: begin
                    if (div_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK:  r_state <= oor ? S_FINAL : S_SETUP1;
                S_SETUP1: r_state <= S_SETUP2;
                S_SETUP2: r_state <= (r_in_ch == 4'd0) ? S_DRAIN : S_MAC;
                S_MAC: begin
                    if (last_c && last_j && last_i) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1 && !r_p2) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Compute datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_row <= s_axis_tdata[33:29];
                r_col <= s_axis_tdata[38:34];
                r_och <= s_axis_tdata[41:39];
            end
            S_HWAIT: begin
                if (div_done) begin
                    r_hout <= span_h[7] ? '0 : div_quo + SW'(1);
                end
            end
            S_WWAIT: begin
                if (div_done) begin
                    r_wout <= span_w[7] ? '0 : div_quo + SW'(1);
                end
            end
            S_CHECK: begin
                r_oor <= oor;
                r_h0  <= $signed({2'b00, row_sy}) - $signed({8'd0, py});
                r_w0  <= $signed({2'b00, col_sx}) - $signed({8'd0, px});
                r_tmp <= tmp_full;
            end
            S_SETUP1: begin
                r_winc <= winc_full;
                r_idx  <= idx_full[12:0];
                r_hw   <= hw_full;
            end
            S_SETUP2: begin
                r_fi     <= fi_full[FW-1:0];
                r_fi_row <= fi_full[FW-1:0];
                r_h      <= r_h0;
                r_w      <= r_w0;
                r_wi     <= {12'd0, r_och};
                r_c      <= '0;
                r_jj     <= '0;
                r_ii     <= '0;
            end
            S_MAC: begin
                // Advance channel, then column, then row of the kernel window
                r_wi <= r_wi + {11'd0, r_out_ch};
                if (!last_c) begin
                    r_c  <= r_c + 4'd1;
                    r_fi <= r_fi + FW'(1);
                end else if (!last_j) begin
                    r_c  <= '0;
                    r_jj <= r_jj + 3'd1;
                    r_w  <= r_w + 11'sd1;
                    r_fi <= r_fi + FW'(1);
                end else begin
                    r_c      <= '0;
                    r_jj     <= '0;
                    r_ii     <= r_ii + 3'd1;
                    r_w      <= r_w0;
                    r_h      <= r_h + 11'sd1;
                    r_fi     <= r_fi_row + $signed({10'd0, r_winc});
                    r_fi_row <= r_fi_row + $signed({10'd0, r_winc});
                end
            end
            default: ;
        endcase
    end

    // Stores
    logic [DW-1:0] feat_mem [2**c2d_pkg::FEAT_AW];
    logic [DW-1:0] wgt_mem  [2**c2d_pkg::WGT_AW];
    logic [DW-1:0] bias_mem [2**c2d_pkg::BIAS_AW];

    always_ff @(posedge i_clk) begin
        if (acc_in && (in_cmd == c2d_pkg::CMD_FEATURE)) begin
            feat_mem[in_addr] <= in_val;
        end
        r_frd <= feat_mem[r_fi[c2d_pkg::FEAT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && (in_cmd == c2d_pkg::CMD_WEIGHT)
            && (in_addr[12:c2d_pkg::WGT_AW] == '0)) begin
            wgt_mem[in_addr[c2d_pkg::WGT_AW-1:0]] <= in_val;
        end
        r_wrd <= wgt_mem[r_wi[c2d_pkg::WGT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && (in_cmd == c2d_pkg::CMD_BIAS)
            && (in_addr[12:c2d_pkg::BIAS_AW] == '0)) begin
            bias_mem[in_addr[c2d_pkg::BIAS_AW-1:0]] <= in_val;
        end
        r_bias <= bias_mem[r_och];
    end

    // Multiply-accumulate pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= (r_state == S_MAC) && tap_ok;
            r_p2 <= r_p1;
        end
    end

    // Multiply then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_frd * r_wrd;
        if (r_state == S_SETUP2) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    // Output register
    logic          r_ovalid;
    logic [79:0]   r_odata;
    logic          r_ostatus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_FINAL) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINAL) && out_free) begin
            r_odata[47:0]  <= (r_oor || relu_zero) ? '0 : sum;
            r_odata[60:48] <= r_oor ? 13'd0 : r_idx;
            r_odata[66:61] <= r_hout[5:0];
            r_odata[72:67] <= r_wout[5:0];
            r_odata[79:73] <= '0;
            r_ostatus      <= r_oor;
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tuser[0] = r_ostatus;

endmodule
